// File: hdl/rlc_pkg.sv
// rlc_pkg: shared constants, register indexes and types of the lux, colour temperature and hsl unit
// no dependencies
package rlc_pkg;

   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_INTEG_TIME = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_SEL   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RED_COEF   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_GREEN_COEF = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_BLUE_COEF  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_GDF        = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_CCT_COEF   = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_CCT_OFFSET = 3'd7;

   localparam logic [7:0]  RST_INTEG_TIME = 8'd0;
   localparam logic [1:0]  RST_GAIN_SEL   = 2'd3;
   localparam logic [15:0] RST_RED_COEF   = 16'd2228;
   localparam logic [15:0] RST_GREEN_COEF = 16'd16384;
   localparam logic [15:0] RST_BLUE_COEF  = 16'hE396;
   localparam logic [15:0] RST_GDF        = 16'd310;
   localparam logic [15:0] RST_CCT_COEF   = 16'd3810;
   localparam logic [15:0] RST_CCT_OFFSET = 16'd1391;

   localparam logic [21:0] CT_MAX = 22'h3F_FFFF;
   localparam logic [8:0]  SHORT_INTEG_MAX = 9'd62;
   localparam int LUX_MAG_W = 54;
   localparam int LUX_DEN_W = 25;

   localparam int LANE_IR  = 0;
   localparam int LANE_R   = 1;
   localparam int LANE_G   = 2;
   localparam int LANE_B   = 3;
   localparam int LANE_CT  = 4;
   localparam int LANE_LUX = 5;
   localparam int LANES_A  = 6;

   localparam int LANE_HSAT = 0;
   localparam int LANE_HUE  = 1;
   localparam int LANES_B   = 2;

   typedef struct packed {
      logic [15:0]          red;
      logic [15:0]          green;
      logic [15:0]          blue;
      logic [15:0]          clear;
      logic [16:0]          ir;
      logic                 sat;
      logic [1:0]           fault;
      logic [LUX_DEN_W-1:0] lux_den;
      logic [31:0]          ct_num;
   } carry_type;

   typedef struct packed {
      logic [16:0] ir;
      logic        sat;
      logic [1:0]  fault;
      logic        neg;
   } side_a_type;

   typedef struct packed {
      logic [15:0] ir_ratio;
      logic        sat;
      logic [1:0]  fault;
      logic [16:0] ir;
      logic [31:0] lux;
      logic [21:0] ct;
      logic [15:0] light;
      logic        achrom;
   } side_b_type;

   function automatic logic [5:0] gain_mult(input logic [1:0] sel);
      logic [5:0] g;
      unique case (sel)
         2'd0: g = 6'd1;
         2'd1: g = 6'd4;
         2'd2: g = 6'd16;
         2'd3: g = 6'd60;
      endcase
      return g;
   endfunction

endpackage

// File: hdl/rgbc_lux_cct_hsl_calc_unit.sv
// rgbc_lux_cct_hsl_calc_unit: lux, colour temperature, ir estimate and hsl from raw rgbc counts
// depends on rlc_pkg and rlc_div_chain
//
//   channel   direction  handshake            payload
//   request   in         start / busy         req_red_count .. req_clear_count
//   response  out        rsp_strobe           rsp_ir_estimate .. rsp_div_fault
//   csr       in         csr_valid/csr_ready  csr_index, csr_wdata
//
// one count set is taken every cycle while busy is low; each result passes the input capture,
// the product stages and two divider rows of NA = max(54, FRAC_BITS+17) and NB = FRAC_BITS+19
// cells (one quotient bit per cell) before the result register
// synchronous reset empties the pipeline; busy is high while reset is held and in the cycle after reset
// results are shown for one cycle and never held back
module rgbc_lux_cct_hsl_calc_unit #(
   parameter int FRAC_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [15:0]                   req_red_count,
   input  logic [15:0]                   req_green_count,
   input  logic [15:0]                   req_blue_count,
   input  logic [15:0]                   req_clear_count,
   output logic                          rsp_strobe,
   output logic [16:0]                   rsp_ir_estimate,
   output logic [15:0]                   rsp_ir_clear_ratio,
   output logic                          rsp_sensor_saturated,
   output logic signed [31:0]            rsp_lux_value,
   output logic [21:0]                   rsp_color_temp,
   output logic [15:0]                   rsp_hue_out,
   output logic [15:0]                   rsp_hsl_saturation,
   output logic [15:0]                   rsp_lightness_out,
   output logic [1:0]                    rsp_div_fault,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [rlc_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [rlc_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import rlc_pkg::*;

   localparam int NA   = (LUX_MAG_W > FRAC_BITS + 17) ? LUX_MAG_W : FRAC_BITS + 17;
   localparam int NB   = FRAC_BITS + 19;
   localparam int DWA  = LUX_DEN_W;
   localparam int DWB  = (FRAC_BITS + 1 > 19) ? FRAC_BITS + 1 : 19;
   localparam int SUMW = (FRAC_BITS + 2 > 17) ? FRAC_BITS + 2 : 17;
   localparam int LAT  = 8 + NA + NB;
   localparam logic [15:0] LIM = (FRAC_BITS >= 16) ? 16'hFFFF : 16'((1 << FRAC_BITS) - 1);
   localparam logic [SUMW-1:0] ONE_S = SUMW'(1) << FRAC_BITS;

   typedef struct packed {
      logic [15:0] ir_ratio;
      logic [15:0] rq;
      logic [15:0] gq;
      logic [15:0] bq;
      logic [21:0] ct;
      logic [31:0] lux;
      logic [16:0] ir;
      logic        sat;
      logic [1:0]  fault;
   } mid_type;

   function automatic logic [15:0] clamp_a(input logic [NA-1:0] q);
      return (q > NA'(LIM)) ? LIM : q[15:0];
   endfunction

   function automatic logic [15:0] clamp_b(input logic [NB-1:0] q);
      return (q > NB'(LIM)) ? LIM : q[15:0];
   endfunction

   // configuration registers
   logic              busy_ff;
   logic [7:0]        integ_ff;
   logic [1:0]        gain_sel_ff;
   logic signed [15:0] red_coef_ff, green_coef_ff, blue_coef_ff;
   logic [15:0]       gdf_ff, cct_coef_ff, cct_off_ff;
   logic              accept;

   assign accept    = start && !busy_ff;
   assign busy      = busy_ff;
   assign csr_ready = !busy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff       <= 1'b1;
         integ_ff      <= RST_INTEG_TIME;
         gain_sel_ff   <= RST_GAIN_SEL;
         red_coef_ff   <= RST_RED_COEF;
         green_coef_ff <= RST_GREEN_COEF;
         blue_coef_ff  <= RST_BLUE_COEF;
         gdf_ff        <= RST_GDF;
         cct_coef_ff   <= RST_CCT_COEF;
         cct_off_ff    <= RST_CCT_OFFSET;
      end else begin
         busy_ff <= 1'b0;
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               CSR_INTEG_TIME: integ_ff      <= csr_wdata[7:0];
               CSR_GAIN_SEL:   gain_sel_ff   <= csr_wdata[1:0];
               CSR_RED_COEF:   red_coef_ff   <= csr_wdata;
               CSR_GREEN_COEF: green_coef_ff <= csr_wdata;
               CSR_BLUE_COEF:  blue_coef_ff  <= csr_wdata;
               CSR_GDF:        gdf_ff        <= csr_wdata;
               CSR_CCT_COEF:   cct_coef_ff   <= csr_wdata;
               CSR_CCT_OFFSET: cct_off_ff    <= csr_wdata;
            endcase
         end
      end
   end

   // input capture
   logic        v0_ff;
   logic [15:0] r0_ff, g0_ff, b0_ff, c0_ff;

   always_ff @(posedge clock) begin
      if (accept) begin
         r0_ff <= req_red_count;
         g0_ff <= req_green_count;
         b0_ff <= req_blue_count;
         c0_ff <= req_clear_count;
      end
   end

   // products, ir, flags and lux divisor
   logic [17:0]          sum_rgb;
   logic [8:0]           cycles;
   logic [14:0]          cyc_gain;
   carry_type            c1_in, c1_ff, c2_ff, c3_ff, c4_ff;
   logic signed [32:0]   pr_in, pg_in, pb_in, pr_ff, pg_ff, pb_ff;
   logic                 v1_ff, v2_ff, v3_ff, v4_ff;

   always_comb begin
      sum_rgb  = 18'(r0_ff) + 18'(g0_ff) + 18'(b0_ff);
      cycles   = 9'd256 - 9'(integ_ff);
      cyc_gain = 15'(cycles * gain_mult(gain_sel_ff));
      c1_in.red     = r0_ff;
      c1_in.green   = g0_ff;
      c1_in.blue    = b0_ff;
      c1_in.clear   = c0_ff;
      c1_in.ir      = (sum_rgb > 18'(c0_ff)) ? 17'((sum_rgb - 18'(c0_ff)) >> 1) : 17'd0;
      c1_in.sat     = (cycles <= SHORT_INTEG_MAX) &&
                      (18'(c0_ff) > 18'(cycles * 18'd768));
      c1_in.fault   = {r0_ff == 16'd0, c0_ff == 16'd0};
      c1_in.lux_den = DWA'({cyc_gain, 10'd0}) + DWA'({cyc_gain, 9'd0});
      c1_in.ct_num  = cct_coef_ff * b0_ff;
      pr_in = red_coef_ff * $signed({1'b0, r0_ff});
      pg_in = green_coef_ff * $signed({1'b0, g0_ff});
      pb_in = blue_coef_ff * $signed({1'b0, b0_ff});
   end

   // lux numerator: weighted sum, times factor, times ten as magnitude and sign
   logic signed [34:0]   wsum_ff;
   logic signed [51:0]   wg_ff;
   logic [51:0]          wg_abs;
   logic [55:0]          mag10;
   logic                 neg4_ff;
   logic [LUX_MAG_W-1:0] mag4_ff;

   always_comb begin
      wg_abs = wg_ff[51] ? 52'(-wg_ff) : 52'(wg_ff);
      mag10  = ({4'd0, wg_abs} << 3) + ({4'd0, wg_abs} << 1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v0_ff <= accept;
         v1_ff <= v0_ff;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      c1_ff   <= c1_in;
      pr_ff   <= pr_in;
      pg_ff   <= pg_in;
      pb_ff   <= pb_in;
      c2_ff   <= c1_ff;
      wsum_ff <= pr_ff + pg_ff + pb_ff;
      c3_ff   <= c2_ff;
      wg_ff   <= wsum_ff * $signed({1'b0, gdf_ff});
      c4_ff   <= c3_ff;
      neg4_ff <= wg_ff[51];
      mag4_ff <= mag10[LUX_MAG_W-1:0];
   end

   // first divider row: ratios, colour temperature, lux
   logic [LANES_A-1:0][NA-1:0]  numa, qa;
   logic [LANES_A-1:0][DWA-1:0] diva, rema;
   side_a_type                  sidea_in, sidea_out;
   logic [$bits(side_a_type)-1:0] sidea_vec_out;
   logic                        va_out;

   always_comb begin
      numa[LANE_IR]  = NA'({c4_ff.ir, {FRAC_BITS{1'b0}}});
      numa[LANE_R]   = NA'({c4_ff.red, {FRAC_BITS{1'b0}}});
      numa[LANE_G]   = NA'({c4_ff.green, {FRAC_BITS{1'b0}}});
      numa[LANE_B]   = NA'({c4_ff.blue, {FRAC_BITS{1'b0}}});
      numa[LANE_CT]  = NA'(c4_ff.ct_num);
      numa[LANE_LUX] = NA'(mag4_ff);
      diva[LANE_IR]  = DWA'(c4_ff.clear);
      diva[LANE_R]   = DWA'(c4_ff.clear);
      diva[LANE_G]   = DWA'(c4_ff.clear);
      diva[LANE_B]   = DWA'(c4_ff.clear);
      diva[LANE_CT]  = DWA'(c4_ff.red);
      diva[LANE_LUX] = c4_ff.lux_den;
      sidea_in.ir    = c4_ff.ir;
      sidea_in.sat   = c4_ff.sat;
      sidea_in.fault = c4_ff.fault;
      sidea_in.neg   = neg4_ff;
   end

   rlc_div_chain #(
      .LANES (LANES_A),
      .NW    (NA),
      .DW    (DWA),
      .SBW   ($bits(side_a_type))
   ) u_chain_a (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (v4_ff),
      .in_num    (numa),
      .in_div    (diva),
      .in_side   (sidea_in),
      .out_valid (va_out),
      .out_quot  (qa),
      .out_rem   (rema),
      .out_side  (sidea_vec_out)
   );

   assign sidea_out = side_a_type'(sidea_vec_out);

   // clamping and saturation
   mid_type     m5_in, m5_ff;
   logic        v5_ff;
   logic [32:0] ct_sum;
   logic [NA-1:0] q_lux;

   always_comb begin
      q_lux  = qa[LANE_LUX];
      ct_sum = 33'(qa[LANE_CT][31:0]) + 33'(cct_off_ff);
      m5_in.ir    = sidea_out.ir;
      m5_in.sat   = sidea_out.sat;
      m5_in.fault = sidea_out.fault;
      m5_in.ir_ratio = sidea_out.fault[0] ? LIM : clamp_a(qa[LANE_IR]);
      m5_in.rq       = sidea_out.fault[0] ? LIM : clamp_a(qa[LANE_R]);
      m5_in.gq       = sidea_out.fault[0] ? LIM : clamp_a(qa[LANE_G]);
      m5_in.bq       = sidea_out.fault[0] ? LIM : clamp_a(qa[LANE_B]);
      if (sidea_out.fault[1] || qa[LANE_CT] > NA'(CT_MAX) || ct_sum > 33'(CT_MAX)) begin
         m5_in.ct = CT_MAX;
      end else begin
         m5_in.ct = ct_sum[21:0];
      end
      if (!sidea_out.neg) begin
         m5_in.lux = (q_lux > NA'(32'h7FFF_FFFF)) ? 32'h7FFF_FFFF : q_lux[31:0];
      end else begin
         m5_in.lux = (q_lux > NA'(33'h0_8000_0000)) ? 32'h8000_0000 : 32'(-q_lux[31:0]);
      end
   end

   // hsl set-up
   logic [15:0]     mx, mn, dd;
   logic [SUMW-1:0] ssum, den_full;
   logic [18:0]     d6;
   logic [19:0]     hnum;
   side_b_type      sideb_in, sideb_ff, sideb_out;
   logic [$bits(side_b_type)-1:0] sideb_vec_out;
   logic [LANES_B-1:0][NB-1:0]  numb_in, numb_ff, qb;
   logic [LANES_B-1:0][DWB-1:0] divb_in, divb_ff, remb;
   logic            v6_ff, vb_out;

   always_comb begin
      mx = (m5_ff.rq > m5_ff.gq) ? m5_ff.rq : m5_ff.gq;
      if (m5_ff.bq > mx) mx = m5_ff.bq;
      mn = (m5_ff.rq < m5_ff.gq) ? m5_ff.rq : m5_ff.gq;
      if (m5_ff.bq < mn) mn = m5_ff.bq;
      dd   = mx - mn;
      d6   = 19'({dd, 2'b00}) + 19'({dd, 1'b0});
      ssum = SUMW'(mx) + SUMW'(mn);
      den_full = (ssum <= ONE_S) ? ssum : (ONE_S << 1) - ssum;
      priority if (mx == m5_ff.rq) begin
         hnum = (m5_ff.gq >= m5_ff.bq) ? 20'(m5_ff.gq - m5_ff.bq)
                                       : 20'(d6) - 20'(m5_ff.bq - m5_ff.gq);
      end else if (mx == m5_ff.gq) begin
         hnum = 20'({dd, 1'b0}) + 20'(m5_ff.bq) - 20'(m5_ff.rq);
      end else begin
         hnum = 20'({dd, 2'b00}) + 20'(m5_ff.rq) - 20'(m5_ff.gq);
      end
      numb_in[LANE_HSAT] = NB'({dd, {FRAC_BITS{1'b0}}});
      numb_in[LANE_HUE]  = NB'({hnum[18:0], {FRAC_BITS{1'b0}}});
      divb_in[LANE_HSAT] = DWB'(den_full);
      divb_in[LANE_HUE]  = DWB'(d6);
      sideb_in.ir_ratio = m5_ff.ir_ratio;
      sideb_in.sat      = m5_ff.sat;
      sideb_in.fault    = m5_ff.fault;
      sideb_in.ir       = m5_ff.ir;
      sideb_in.lux      = m5_ff.lux;
      sideb_in.ct       = m5_ff.ct;
      sideb_in.light    = 16'(ssum >> 1);
      sideb_in.achrom   = (mx == mn);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
      end else begin
         v5_ff <= va_out;
         v6_ff <= v5_ff;
      end
   end

   always_ff @(posedge clock) begin
      m5_ff    <= m5_in;
      numb_ff  <= numb_in;
      divb_ff  <= divb_in;
      sideb_ff <= sideb_in;
   end

   // second divider row: saturation and hue
   rlc_div_chain #(
      .LANES (LANES_B),
      .NW    (NB),
      .DW    (DWB),
      .SBW   ($bits(side_b_type))
   ) u_chain_b (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (v6_ff),
      .in_num    (numb_ff),
      .in_div    (divb_ff),
      .in_side   (sideb_ff),
      .out_valid (vb_out),
      .out_quot  (qb),
      .out_rem   (remb),
      .out_side  (sideb_vec_out)
   );

   assign sideb_out = side_b_type'(sideb_vec_out);

   // result register
   logic        rsp_strobe_ff;
   logic [16:0] ir_ff;
   logic [15:0] ir_ratio_ff, hue_ff, hsat_ff, light_ff;
   logic        sat_ff;
   logic [31:0] lux_ff;
   logic [21:0] ct_ff;
   logic [1:0]  fault_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= vb_out;
      end
   end

   always_ff @(posedge clock) begin
      ir_ff       <= sideb_out.ir;
      ir_ratio_ff <= sideb_out.ir_ratio;
      sat_ff      <= sideb_out.sat;
      lux_ff      <= sideb_out.lux;
      ct_ff       <= sideb_out.ct;
      light_ff    <= sideb_out.light;
      fault_ff    <= sideb_out.fault;
      hsat_ff     <= sideb_out.achrom ? 16'd0 : clamp_b(qb[LANE_HSAT]);
      hue_ff      <= sideb_out.achrom ? 16'd0 : clamp_b(qb[LANE_HUE]);
   end

   assign rsp_strobe           = rsp_strobe_ff;
   assign rsp_ir_estimate      = ir_ff;
   assign rsp_ir_clear_ratio   = ir_ratio_ff;
   assign rsp_sensor_saturated = sat_ff;
   assign rsp_lux_value        = lux_ff;
   assign rsp_color_temp       = ct_ff;
   assign rsp_hue_out          = hue_ff;
   assign rsp_hsl_saturation   = hsat_ff;
   assign rsp_lightness_out    = light_ff;
   assign rsp_div_fault        = fault_ff;

   // every result stems from a transfer exactly one pipeline length earlier
   a_latency: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start && !busy, LAT))
      else $error("result without matching request transfer");

   a_clear_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_div_fault[0]) |->
         (rsp_ir_clear_ratio == LIM && rsp_hue_out == 16'd0 &&
          rsp_hsl_saturation == 16'd0 && rsp_lightness_out == LIM))
      else $error("zero clear count not achromatic at limit");

   a_red_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_div_fault[1]) |-> rsp_color_temp == CT_MAX)
      else $error("zero red count without saturated colour temperature");

endmodule

// File: hdl/rlc_div_cell.sv
// rlc_div_cell: one restoring division step for several lanes, with a sideband stage
// no dependencies
module rlc_div_cell #(
   parameter int LANES = 1,
   parameter int NW    = 8,
   parameter int DW    = 8,
   parameter int SBW   = 1
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       in_valid,
   input  logic [LANES-1:0][NW-1:0]   in_num,
   input  logic [LANES-1:0][DW-1:0]   in_rem,
   input  logic [LANES-1:0][DW-1:0]   in_div,
   input  logic [SBW-1:0]             in_side,
   output logic                       out_valid,
   output logic [LANES-1:0][NW-1:0]   out_num,
   output logic [LANES-1:0][DW-1:0]   out_rem,
   output logic [LANES-1:0][DW-1:0]   out_div,
   output logic [SBW-1:0]             out_side
);

   logic                     valid_ff;
   logic [LANES-1:0][NW-1:0] num_ff, num_in;
   logic [LANES-1:0][DW-1:0] rem_ff, rem_in;
   logic [LANES-1:0][DW-1:0] div_ff;
   logic [SBW-1:0]           side_ff;
   logic [LANES-1:0][DW:0]   trial;
   logic [LANES-1:0]         ge;

   always_comb begin
      for (int i = 0; i < LANES; i++) begin
         trial[i]  = {in_rem[i], in_num[i][NW-1]};
         ge[i]     = trial[i] >= {1'b0, in_div[i]};
         rem_in[i] = ge[i] ? DW'(trial[i] - {1'b0, in_div[i]}) : trial[i][DW-1:0];
         num_in[i] = {in_num[i][NW-2:0], ge[i]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      num_ff  <= num_in;
      rem_ff  <= rem_in;
      div_ff  <= in_div;
      side_ff <= in_side;
   end

   assign out_valid = valid_ff;
   assign out_num   = num_ff;
   assign out_rem   = rem_ff;
   assign out_div   = div_ff;
   assign out_side  = side_ff;

endmodule

// File: hdl/rlc_div_chain.sv
// rlc_div_chain: row of division cells, one quotient bit per cell, lanes side by side
// depends on rlc_div_cell
module rlc_div_chain #(
   parameter int LANES = 1,
   parameter int NW    = 8,
   parameter int DW    = 8,
   parameter int SBW   = 1
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       in_valid,
   input  logic [LANES-1:0][NW-1:0]   in_num,
   input  logic [LANES-1:0][DW-1:0]   in_div,
   input  logic [SBW-1:0]             in_side,
   output logic                       out_valid,
   output logic [LANES-1:0][NW-1:0]   out_quot,
   output logic [LANES-1:0][DW-1:0]   out_rem,
   output logic [SBW-1:0]             out_side
);

   logic [NW:0]                       valid_s;
   logic [NW:0][LANES-1:0][NW-1:0]    num_s;
   logic [NW:0][LANES-1:0][DW-1:0]    rem_s;
   logic [NW:0][LANES-1:0][DW-1:0]    div_s;
   logic [NW:0][SBW-1:0]              side_s;

   assign valid_s[0] = in_valid;
   assign num_s[0]   = in_num;
   assign rem_s[0]   = '0;
   assign div_s[0]   = in_div;
   assign side_s[0]  = in_side;

   for (genvar k = 0; k < NW; k++) begin : g_cell
      rlc_div_cell #(
         .LANES (LANES),
         .NW    (NW),
         .DW    (DW),
         .SBW   (SBW)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (valid_s[k]),
         .in_num    (num_s[k]),
         .in_rem    (rem_s[k]),
         .in_div    (div_s[k]),
         .in_side   (side_s[k]),
         .out_valid (valid_s[k+1]),
         .out_num   (num_s[k+1]),
         .out_rem   (rem_s[k+1]),
         .out_div   (div_s[k+1]),
         .out_side  (side_s[k+1])
      );
   end

   assign out_valid = valid_s[NW];
   assign out_quot  = num_s[NW];
   assign out_rem   = rem_s[NW];
   assign out_side  = side_s[NW];

endmodule

// File: dv/tb_top.sv
// tb_top: self-checking testbench of rgbc_lux_cct_hsl_calc_unit
// drives count sets and csr writes, predicts each result with its own integer model
// depends on rlc_pkg and the unit under test
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import rlc_pkg::*;

   localparam int WATCHDOG_LIMIT = 5000;
   localparam int DRAIN_CYCLES = 120;

   typedef struct {
      logic [16:0] ir;
      logic [15:0] ir_ratio;
      logic        sat;
      logic [31:0] lux;
      logic [21:0] ct;
      logic [15:0] hue;
      logic [15:0] hsat;
      logic [15:0] light;
      logic [1:0]  fault;
   } reading_type;

   logic clock, reset, start, busy;
   logic [15:0] req_red_count, req_green_count, req_blue_count, req_clear_count;
   logic rsp_strobe, rsp_sensor_saturated;
   logic [16:0] rsp_ir_estimate;
   logic [15:0] rsp_ir_clear_ratio, rsp_hue_out, rsp_hsl_saturation, rsp_lightness_out;
   logic signed [31:0] rsp_lux_value;
   logic [21:0] rsp_color_temp;
   logic [1:0] rsp_div_fault;
   logic csr_valid, csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   // shadow of the csr bank
   logic [7:0]  cfg_integ;
   logic [1:0]  cfg_gain;
   logic [15:0] cfg_red_coef, cfg_green_coef, cfg_blue_coef, cfg_gdf, cfg_cct_coef;
   logic [15:0] cfg_cct_offset;

   reading_type pending_readings[$];
   int err_count = 0;
   int idle_cycles = 0;
   int idle_pct = 0;

   rgbc_lux_cct_hsl_calc_unit dut (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic longint unsigned ratio_q16(longint unsigned num, longint unsigned den);
      longint unsigned q;
      if (den == 0) return 65535;
      q = (num << 16) / den;
      return (q > 65535) ? 65535 : q;
   endfunction

   function automatic reading_type predict_reading(logic [15:0] r, logic [15:0] g,
                                                   logic [15:0] b, logic [15:0] c);
      reading_type res;
      longint unsigned cyc, sum, ir, ct, rq, gq, bq, mx, mn, s, d, den, num, hue, hsat;
      longint unsigned gm;
      longint wsum, lux;
      cyc = 256 - longint'(cfg_integ);
      sum = longint'(r) + longint'(g) + longint'(b);
      ir = (sum > c) ? (sum - c) / 2 : 0;
      res.fault = {r == 0, c == 0};
      res.sat = (cyc <= 62) && (longint'(c) > 768 * cyc);
      case (cfg_gain)
         2'd0: gm = 1;
         2'd1: gm = 4;
         2'd2: gm = 16;
         default: gm = 60;
      endcase
      wsum = longint'($signed(cfg_red_coef)) * longint'(r)
           + longint'($signed(cfg_green_coef)) * longint'(g)
           + longint'($signed(cfg_blue_coef)) * longint'(b);
      lux = (wsum * longint'(cfg_gdf) * 10) / longint'(1536 * cyc * gm);
      if (lux > 64'sd2147483647) lux = 64'sd2147483647;
      if (lux < -64'sd2147483648) lux = -64'sd2147483648;
      if (r == 0) ct = 4194303;
      else begin
         ct = (longint'(cfg_cct_coef) * b) / r + cfg_cct_offset;
         if (ct > 4194303) ct = 4194303;
      end
      rq = ratio_q16(r, c);
      gq = ratio_q16(g, c);
      bq = ratio_q16(b, c);
      mx = (rq > gq) ? rq : gq;
      if (bq > mx) mx = bq;
      mn = (rq < gq) ? rq : gq;
      if (bq < mn) mn = bq;
      s = mx + mn;
      hue = 0;
      hsat = 0;
      if (mx != mn) begin
         d = mx - mn;
         den = (s <= 65536) ? s : (131072 - s);
         hsat = (d << 16) / den;
         if (hsat > 65535) hsat = 65535;
         if (mx == rq) num = (gq >= bq) ? (gq - bq) : (6 * d - (bq - gq));
         else if (mx == gq) num = 2 * d + bq - rq;
         else num = 4 * d + rq - gq;
         hue = (num << 16) / (6 * d);
         if (hue > 65535) hue = 65535;
      end
      res.ir = ir[16:0];
      res.ir_ratio = 16'(ratio_q16(ir, c));
      res.lux = lux[31:0];
      res.ct = ct[21:0];
      res.hue = hue[15:0];
      res.hsat = hsat[15:0];
      res.light = s[16:1];
      return res;
   endfunction

   task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
      if (exp_v !== act_v) begin
         err_count++;
         if (err_count <= 10)
            $display("mismatch %s: expected %0h got %0h at %0t", name, exp_v, act_v, $time);
      end
   endtask

   always @(posedge clock) begin
      reading_type exp_r;
      if (!reset && rsp_strobe) begin
         if (pending_readings.size() == 0) begin
            err_count++;
            if (err_count <= 10) $display("unexpected result at %0t", $time);
         end else begin
            exp_r = pending_readings.pop_front();
            check_field("ir_estimate", 32'(exp_r.ir), 32'(rsp_ir_estimate));
            check_field("ir_clear_ratio", 32'(exp_r.ir_ratio), 32'(rsp_ir_clear_ratio));
            check_field("sensor_saturated", 32'(exp_r.sat), 32'(rsp_sensor_saturated));
            check_field("lux_value", exp_r.lux, rsp_lux_value);
            check_field("color_temp", 32'(exp_r.ct), 32'(rsp_color_temp));
            check_field("hue_out", 32'(exp_r.hue), 32'(rsp_hue_out));
            check_field("hsl_saturation", 32'(exp_r.hsat), 32'(rsp_hsl_saturation));
            check_field("lightness_out", 32'(exp_r.light), 32'(rsp_lightness_out));
            check_field("div_fault", 32'(exp_r.fault), 32'(rsp_div_fault));
         end
      end
   end

   always @(posedge clock) begin
      if ((start && !busy) || rsp_strobe || (csr_valid && csr_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   task automatic send_counts(logic [15:0] r, logic [15:0] g, logic [15:0] b, logic [15:0] c);
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start <= 1'b1;
      req_red_count <= r;
      req_green_count <= g;
      req_blue_count <= b;
      req_clear_count <= c;
      do @(posedge clock); while (busy);
      pending_readings.push_back(predict_reading(r, g, b, c));
   endtask

   task automatic wait_drained();
      start <= 1'b0;
      while (pending_readings.size() != 0) @(posedge clock);
   endtask

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [15:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_INTEG_TIME: cfg_integ = val[7:0];
         CSR_GAIN_SEL:   cfg_gain = val[1:0];
         CSR_RED_COEF:   cfg_red_coef = val;
         CSR_GREEN_COEF: cfg_green_coef = val;
         CSR_BLUE_COEF:  cfg_blue_coef = val;
         CSR_GDF:        cfg_gdf = val;
         CSR_CCT_COEF:   cfg_cct_coef = val;
         default:        cfg_cct_offset = val;
      endcase
   endtask

   task automatic set_config(logic [7:0] integ, logic [1:0] gain, logic [15:0] rc,
                             logic [15:0] gc, logic [15:0] bc, logic [15:0] gdf,
                             logic [15:0] cc, logic [15:0] co);
      wait_drained();
      write_csr(CSR_INTEG_TIME, {8'd0, integ});
      write_csr(CSR_GAIN_SEL, {14'd0, gain});
      write_csr(CSR_RED_COEF, rc);
      write_csr(CSR_GREEN_COEF, gc);
      write_csr(CSR_BLUE_COEF, bc);
      write_csr(CSR_GDF, gdf);
      write_csr(CSR_CCT_COEF, cc);
      write_csr(CSR_CCT_OFFSET, co);
      csr_valid <= 1'b0;
   endtask

   task automatic send_random_counts();
      logic [15:0] r, g, b, c;
      int mode;
      mode = int'($urandom_range(9));
      c = 16'($urandom);
      r = 16'($urandom);
      g = 16'($urandom);
      b = 16'($urandom);
      if (mode <= 4) begin
         r = 16'($urandom_range(0, c));
         g = 16'($urandom_range(0, c));
         b = 16'($urandom_range(0, c));
      end else if (mode == 7) begin
         r = 16'($urandom_range(15));
         g = 16'($urandom_range(15));
         b = 16'($urandom_range(15));
         c = 16'($urandom_range(15));
      end else if (mode == 8) begin
         g = r;
         b = r;
      end else if (mode == 9) begin
         case ($urandom_range(3))
            0: r = 16'd0;
            1: c = 16'd0;
            2: g = 16'd0;
            default: b = 16'd0;
         endcase
      end
      send_counts(r, g, b, c);
   endtask

   task automatic test_directed_reset_config();
      send_counts(16'd0, 16'd0, 16'd0, 16'd0);
      send_counts(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      send_counts(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd0);
      send_counts(16'd0, 16'd500, 16'd300, 16'd1000);
      send_counts(16'd400, 16'd400, 16'd400, 16'd1000);
      send_counts(16'd900, 16'd200, 16'd100, 16'd1000);
      send_counts(16'd900, 16'd100, 16'd200, 16'd1000);
      send_counts(16'd200, 16'd900, 16'd100, 16'd1000);
      send_counts(16'd100, 16'd200, 16'd900, 16'd1000);
      send_counts(16'd3000, 16'd100, 16'd50, 16'd1000);
      send_counts(16'd1, 16'hFFFF, 16'd1, 16'd1);
      send_counts(16'h5555, 16'hAAAA, 16'h3333, 16'hCCCC);
      send_counts(16'hAAAA, 16'h5555, 16'hCCCC, 16'h3333);
      // pause until every result is back
      wait_drained();
      send_counts(16'd7000, 16'd8000, 16'd6000, 16'd20000);
   endtask

   task automatic test_extreme_configs();
      set_config(8'd255, 2'd0, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      send_counts(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      send_counts(16'd10, 16'd10, 16'd10, 16'd769);
      send_counts(16'd10, 16'd10, 16'd10, 16'd768);
      send_counts(16'd1, 16'hFFFF, 16'd0, 16'd0);
      set_config(8'd194, 2'd1, 16'h8000, 16'h8000, 16'h8000, 16'd1, 16'd0, 16'd0);
      send_counts(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      send_counts(16'd5, 16'd7, 16'd9, 16'd47617);
      send_counts(16'd5, 16'd7, 16'd9, 16'd47616);
      set_config(8'd193, 2'd2, 16'h7FFF, 16'h8000, 16'd0, 16'd1, 16'd1, 16'd0);
      send_counts(16'd1000, 16'd2000, 16'd3000, 16'hFFFF);
      repeat (40) send_random_counts();
   endtask

   task automatic test_random_configs();
      int phase_pct[3] = '{0, 69, 21};
      for (int k = 0; k < 9; k++) begin
         set_config($urandom_range(3) == 0 ? 8'($urandom_range(194, 255)) : 8'($urandom),
                    2'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                    16'($urandom_range(1, 65535)), 16'($urandom), 16'($urandom));
         idle_pct = phase_pct[k % 3];
         repeat (85) send_random_counts();
      end
   endtask

   initial begin
      reset = 1'b1;
      start = 1'b0;
      req_red_count = '0;
      req_green_count = '0;
      req_blue_count = '0;
      req_clear_count = '0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      cfg_integ = RST_INTEG_TIME;
      cfg_gain = RST_GAIN_SEL;
      cfg_red_coef = RST_RED_COEF;
      cfg_green_coef = RST_GREEN_COEF;
      cfg_blue_coef = RST_BLUE_COEF;
      cfg_gdf = RST_GDF;
      cfg_cct_coef = RST_CCT_COEF;
      cfg_cct_offset = RST_CCT_OFFSET;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_reset_config();
      test_extreme_configs();
      test_random_configs();
      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (err_count == 0 && pending_readings.size() == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
